// File: rtl/core/srbmc_pkg.sv
// ----------------------------------------------------------------------------
// srbmc_pkg: shared types and constants for the serial ring buffer block
// Request and result structures, event codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package srbmc_pkg;

	// Default number of slots in each ring; one slot always stays empty.
	localparam int unsigned DEPTH_DEFAULT = 16;

	// Delimiter value after reset: the dollar sign.
	localparam logic [7:0] DELIM_RESET = 8'd36;

	// Upper limit of the message counter.
	localparam logic [3:0] COUNT_MAX = 4'd15;

	// Event codes carried in the kind field.
	localparam logic [1:0] KIND_LINE_RX = 2'd0;
	localparam logic [1:0] KIND_TX_DONE = 2'd1;
	localparam logic [1:0] KIND_POP     = 2'd2;
	localparam logic [1:0] KIND_PUSH    = 2'd3;

	// One request: an event and its byte.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
	} in_item_t;

	// One result of an event.
	typedef struct packed {
		logic       line_valid;
		logic [7:0] line_byte;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       accepted;
		logic [3:0] message_count;
		logic       transmitter_busy;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/srbmc_ring.sv
// ----------------------------------------------------------------------------
// srbmc_ring: byte storage of one ring
// One write port and one registered read port with write-through.
// ----------------------------------------------------------------------------
`default_nettype none

module srbmc_ring #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned PTR_W = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [PTR_W-1:0] waddr,
	input  wire logic [7:0]       wdata,
	input  wire logic [PTR_W-1:0] raddr,
	output logic      [7:0]       rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; a byte written to the slot being read is passed through.
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/srbmc_ctrl.sv
// ----------------------------------------------------------------------------
// srbmc_ctrl: ring pointers, transmitter flag and message counter
// Handles one registered request per cycle and registers its result.
// ----------------------------------------------------------------------------
`default_nettype none

module srbmc_ctrl #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned PTR_W = $clog2(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s1,
	input  wire srbmc_pkg::in_item_t item_s1,
	input  wire logic [7:0]          delimiter,
	input  wire logic [7:0]          rx_head,
	input  wire logic [7:0]          tx_head,
	output logic                     rx_we,
	output logic      [PTR_W-1:0]    rx_waddr,
	output logic      [PTR_W-1:0]    rx_raddr,
	output logic                     tx_we,
	output logic      [PTR_W-1:0]    tx_waddr,
	output logic      [PTR_W-1:0]    tx_raddr,
	output logic                     done,
	output srbmc_pkg::result_t       result
);

	import srbmc_pkg::*;

	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

	logic [PTR_W-1:0] rx_wr_q, rx_rd_q, tx_wr_q, tx_rd_q;
	logic [PTR_W-1:0] rx_wr_d, rx_rd_d, tx_wr_d, tx_rd_d;
	logic [PTR_W-1:0] rx_wr_inc, rx_rd_inc, tx_wr_inc, tx_rd_inc;
	logic             busy_q, busy_d;
	logic [3:0]       count_q, count_d;
	logic             done_s2;
	result_t          res_d, result_s2;
	logic             rx_full, rx_empty, tx_full, tx_empty;

	// Pointer increments wrap at the last slot.
	assign rx_wr_inc = (rx_wr_q == LAST_SLOT) ? '0 : rx_wr_q + 1'b1;
	assign rx_rd_inc = (rx_rd_q == LAST_SLOT) ? '0 : rx_rd_q + 1'b1;
	assign tx_wr_inc = (tx_wr_q == LAST_SLOT) ? '0 : tx_wr_q + 1'b1;
	assign tx_rd_inc = (tx_rd_q == LAST_SLOT) ? '0 : tx_rd_q + 1'b1;

	assign rx_full  = (rx_wr_inc == rx_rd_q);
	assign rx_empty = (rx_wr_q == rx_rd_q);
	assign tx_full  = (tx_wr_inc == tx_rd_q);
	assign tx_empty = (tx_wr_q == tx_rd_q);

	// Event handling for the request in the first stage.
	always_comb begin
		rx_wr_d = rx_wr_q;
		rx_rd_d = rx_rd_q;
		tx_wr_d = tx_wr_q;
		tx_rd_d = tx_rd_q;
		busy_d  = busy_q;
		count_d = count_q;
		rx_we   = 1'b0;
		tx_we   = 1'b0;
		res_d   = '0;
		if (valid_s1) begin
			unique case (item_s1.kind)
				KIND_LINE_RX: begin
					if (!rx_full) begin
						rx_we          = 1'b1;
						rx_wr_d        = rx_wr_inc;
						res_d.accepted = 1'b1;
						if ((item_s1.data_byte == delimiter) && (count_q != COUNT_MAX)) begin
							count_d = count_q + 4'd1;
						end
					end
				end
				KIND_TX_DONE: begin
					if (!tx_empty) begin
						res_d.line_valid = 1'b1;
						res_d.line_byte  = tx_head;
						tx_rd_d          = tx_rd_inc;
					end else begin
						busy_d = 1'b0;
					end
				end
				KIND_POP: begin
					if (!rx_empty) begin
						rx_rd_d          = rx_rd_inc;
						res_d.read_valid = 1'b1;
						res_d.read_byte  = rx_head;
						if ((rx_head == delimiter) && (count_q != 4'd0)) begin
							count_d = count_q - 4'd1;
						end
					end
				end
				KIND_PUSH: begin
					if (!tx_full) begin
						tx_we          = 1'b1;
						tx_wr_d        = tx_wr_inc;
						res_d.accepted = 1'b1;
						// An idle transmitter has an empty ring: the byte goes out at once.
						if (!busy_q) begin
							busy_d           = 1'b1;
							res_d.line_valid = 1'b1;
							res_d.line_byte  = item_s1.data_byte;
							tx_rd_d          = tx_rd_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
		res_d.message_count    = count_d;
		res_d.transmitter_busy = busy_d;
	end

	assign rx_waddr = rx_wr_q;
	assign tx_waddr = tx_wr_q;

	// Storage is read at the next head so the head byte is ready next cycle.
	assign rx_raddr = rx_rd_d;
	assign tx_raddr = tx_rd_d;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wr_q <= '0;
			rx_rd_q <= '0;
			tx_wr_q <= '0;
			tx_rd_q <= '0;
			busy_q  <= 1'b0;
			count_q <= 4'd0;
			done_s2 <= 1'b0;
		end else begin
			rx_wr_q <= rx_wr_d;
			rx_rd_q <= rx_rd_d;
			tx_wr_q <= tx_wr_d;
			tx_rd_q <= tx_rd_d;
			busy_q  <= busy_d;
			count_q <= count_d;
			done_s2 <= valid_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		result_s2 <= res_d;
	end

	assign done   = done_s2;
	assign result = result_s2;

endmodule

`default_nettype wire

// File: rtl/core/serial_ring_buffers_message_count.sv
// ----------------------------------------------------------------------------
// serial_ring_buffers_message_count: receive and transmit rings of a serial port
// Buffers line bytes, feeds the transmitter and counts delimited messages.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which start is high; busy never rises.
// Each request gives exactly one result: the request is held in the input register
// and done rises together with its result in the result register (one input
// register, one result register). The receiver cannot stall, so done is a
// one-cycle strobe that must be captured when it appears.
// The delimiter register should only be written when no request is in flight.
`default_nettype none

module serial_ring_buffers_message_count #(
	parameter int unsigned DEPTH = srbmc_pkg::DEPTH_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire srbmc_pkg::in_item_t in_item,
	output logic                     done,
	output srbmc_pkg::result_t       result,
	input  wire logic                delimiter_we,
	input  wire logic [7:0]          delimiter_wdata
);

	import srbmc_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);

	logic             valid_s1;
	in_item_t         item_s1;
	logic [7:0]       delimiter_q;
	logic [7:0]       rx_head, tx_head;
	logic             rx_we, tx_we;
	logic [PTR_W-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;

	// Every cycle can take a new request.
	assign busy = 1'b0;

	// Delimiter register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DELIM_RESET;
		end else if (delimiter_we) begin
			delimiter_q <= delimiter_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
	end

	// Receive ring storage.
	srbmc_ring #(
		.DEPTH(DEPTH),
		.PTR_W(PTR_W)
	) u_rx_ring (
		.clk  (clk),
		.we   (rx_we),
		.waddr(rx_waddr),
		.wdata(item_s1.data_byte),
		.raddr(rx_raddr),
		.rdata(rx_head)
	);

	// Transmit ring storage.
	srbmc_ring #(
		.DEPTH(DEPTH),
		.PTR_W(PTR_W)
	) u_tx_ring (
		.clk  (clk),
		.we   (tx_we),
		.waddr(tx_waddr),
		.wdata(item_s1.data_byte),
		.raddr(tx_raddr),
		.rdata(tx_head)
	);

	// Pointers, flags and result.
	srbmc_ctrl #(
		.DEPTH(DEPTH),
		.PTR_W(PTR_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.delimiter(delimiter_q),
		.rx_head  (rx_head),
		.tx_head  (tx_head),
		.rx_we    (rx_we),
		.rx_waddr (rx_waddr),
		.rx_raddr (rx_raddr),
		.tx_we    (tx_we),
		.tx_waddr (tx_waddr),
		.tx_raddr (tx_raddr),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire
